>>> sv/date_range_overlap_days_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date range overlap block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DATE_RANGE_OVERLAP_DAYS_TOP_MACROS_SVH
`define DATE_RANGE_OVERLAP_DAYS_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define DROD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define DROD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset as well
`define DROD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/drod_pkg.sv
// ----------------------------------------------------------------------------
// drod_pkg
// Widths, calendar tables and pipeline stage types for the overlap counter.
// ----------------------------------------------------------------------------
package drod_pkg;

   localparam int YEAR_W       = 14;
   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;
   localparam int DATE_W       = YEAR_W + MONTH_W + DAY_W;
   localparam int NUM_DATES    = 4;
   localparam int DNUM_W       = 23;   // day number of any 14-bit year fits
   localparam int COUNT_W      = 22;
   localparam int OFFS_W       = 9;
   localparam int RECIP_W      = 13;
   localparam int PROD_W       = YEAR_W + RECIP_W;
   localparam int RECIP_SHIFT  = 19;
   localparam int Q_W          = PROD_W - RECIP_SHIFT;
   localparam int MAX_YEAR_DEF = 9999;
   localparam int REQ_DATA_W   = ((NUM_DATES * DATE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((COUNT_W + 7) / 8) * 8;

   // x / 100 == (x * 5243) >> 19 for every x below 43699
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;
   localparam logic [DNUM_W-1:0]  YEAR_DAYS = 23'd365;
   localparam logic [MONTH_W-1:0] FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] DEC       = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [YEAR_W-1:0]  prev_year;
      logic [PROD_W-1:0]  prod_prev;
      logic [PROD_W-1:0]  prod_year;
      logic               bad;
   } s1_date_type;

   typedef struct packed {
      logic [DNUM_W-1:0] base;
      logic [OFFS_W-1:0] offs;
      logic              ok;
   } s2_date_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [OFFS_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [OFFS_W-1:0] n;
      unique case (month)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

>>> sv/date_range_overlap_days_top.sv
// Throughput: one transaction per cycle; each stage holds only while the next is full.
// Stages: range check and reciprocal multiplies, leap/validity and year base,
//   day number, span bounds, count with saturation (output register).
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
// date_range_overlap_days_top
// Inclusive day count shared by two Gregorian date periods, five-stage pipeline.
// ----------------------------------------------------------------------------
module date_range_overlap_days_top #(
   parameter int MAX_YEAR = drod_pkg::MAX_YEAR_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // low to high: a_start_year, a_start_month, a_start_day, a_end_year, a_end_month,
   // a_end_day, b_start_year, b_start_month, b_start_day, b_end_year, b_end_month,
   // b_end_day, zero pad
   input  logic [drod_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // low to high: overlap_days, zero pad
   output logic [drod_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // date_error
   output logic                            rsp_tuser
);
   import drod_pkg::*;

   localparam logic [YEAR_W:0] YEAR_LIMIT = (YEAR_W+1)'(MAX_YEAR);

   // date order in the transaction: A start, A end, B start, B end
   localparam int A_START = 0;
   localparam int A_END   = 1;
   localparam int B_START = 2;
   localparam int B_END   = 3;

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic              rdy1, rdy2, rdy3, rdy4, rdy5;

   s1_date_type       s1_ff [NUM_DATES];
   s1_date_type       s1_in [NUM_DATES];
   s2_date_type       s2_ff [NUM_DATES];
   s2_date_type       s2_in [NUM_DATES];
   logic [DNUM_W-1:0] num_ff [NUM_DATES];
   logic [DNUM_W-1:0] num_in [NUM_DATES];
   logic              ok3_ff, ok3_in;
   logic [DNUM_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic              ok4_ff;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic              err_ff;

   // backpressure: a stage takes new data when empty or when it drains
   assign rdy5       = !v5_ff || rsp_tready;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   // stage 1: field range checks and the /100 reciprocal products
   always_comb begin
      for (int i = 0; i < NUM_DATES; i++) begin
         date_type dt;
         dt = date_type'(req_tdata[i*DATE_W +: DATE_W]);
         s1_in[i].year      = dt.year;
         s1_in[i].month     = dt.month;
         s1_in[i].day       = dt.day;
         s1_in[i].prev_year = dt.year - 1'b1;
         s1_in[i].prod_prev = PROD_W'(dt.year - 1'b1) * PROD_W'(RECIP_100);
         s1_in[i].prod_year = PROD_W'(dt.year) * PROD_W'(RECIP_100);
         s1_in[i].bad       = (dt.year == '0) || ({1'b0, dt.year} > YEAR_LIMIT) ||
                              (dt.month == '0) || (dt.month > DEC) || (dt.day == '0);
      end
   end

   // stage 2: leap year, day limit, year base and in-year offset
   always_comb begin
      for (int i = 0; i < NUM_DATES; i++) begin
         logic [Q_W-1:0]    q100, q400, yq;
         logic [YEAR_W-1:0] yq_x100;
         logic              leap;
         q100    = s1_ff[i].prod_prev[PROD_W-1:RECIP_SHIFT];
         q400    = q100 >> 2;
         yq      = s1_ff[i].prod_year[PROD_W-1:RECIP_SHIFT];
         yq_x100 = YEAR_W'(yq) * CENTURY;
         // divisible by 4, and by 400 when it is a century year
         leap    = (s1_ff[i].year[1:0] == 2'b00) &&
                   ((yq_x100 != s1_ff[i].year) || (yq[1:0] == 2'b00));
         s2_in[i].ok   = !s1_ff[i].bad &&
                         (s1_ff[i].day <= month_days(s1_ff[i].month, leap));
         s2_in[i].base = DNUM_W'(s1_ff[i].prev_year) * YEAR_DAYS
                       + DNUM_W'(s1_ff[i].prev_year[YEAR_W-1:2])
                       - DNUM_W'(q100) + DNUM_W'(q400);
         s2_in[i].offs = days_before(s1_ff[i].month)
                       + OFFS_W'(leap && (s1_ff[i].month > FEB))
                       + OFFS_W'(s1_ff[i].day);
      end
   end

   // stage 3: day numbers
   always_comb begin
      ok3_in = 1'b1;
      for (int i = 0; i < NUM_DATES; i++) begin
         num_in[i] = s2_ff[i].base + DNUM_W'(s2_ff[i].offs);
         ok3_in    = ok3_in && s2_ff[i].ok;
      end
   end

   // stage 4: later start, earlier end
   assign lo_in = (num_ff[A_START] > num_ff[B_START]) ? num_ff[A_START] : num_ff[B_START];
   assign hi_in = (num_ff[A_END] < num_ff[B_END]) ? num_ff[A_END] : num_ff[B_END];

   // stage 5: inclusive count, saturated to the output width
   always_comb begin
      logic [DNUM_W-1:0] span;
      span   = hi_ff - lo_ff + 1'b1;
      cnt_in = '0;
      if (ok4_ff && (lo_ff <= hi_ff)) begin
         cnt_in = (span[DNUM_W-1:COUNT_W] != '0) ? '1 : span[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         num_ff <= num_in;
         ok3_ff <= ok3_in;
      end
      if (rdy4) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         ok4_ff <= ok3_ff;
      end
      if (rdy5) begin
         cnt_ff <= cnt_in;
         err_ff <= !ok4_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = RSP_DATA_W'(cnt_ff);
   assign rsp_tuser  = err_ff;

endmodule

>>> sv/drod_checker.sv
// ----------------------------------------------------------------------------
// drod_checker
// Port-level checks on the overlap counter's result channel and input ready, bound to the top.
// ----------------------------------------------------------------------------
`include "date_range_overlap_days_top_macros.svh"

module drod_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [drod_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import drod_pkg::*;

   // an invalid date forces a zero count
   `DROD_ASSERT_NOW(err_zero_count, rsp_tvalid && rsp_tuser, rsp_tdata[COUNT_W-1:0] == '0, "date_error with nonzero overlap_days")

   // pad bits above the count stay clear
   `DROD_ASSERT_NOW(pad_zero, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:COUNT_W] == '0, "rsp_tdata pad bits set")

   // nothing comes out of a pipeline that reset just emptied
   `DROD_ASSERT_ALWAYS(reset_empty, reset, !rsp_tvalid, "rsp_tvalid right after reset")

   // a stalled result transaction holds
   `DROD_ASSERT_NEXT(rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp transaction changed")

   // an empty output stage lets every stage advance, so the input is open
   `DROD_ASSERT_NOW(ready_when_empty, !rsp_tvalid, req_tready, "req_tready low with empty output stage")

endmodule

bind date_range_overlap_days_top drod_checker u_drod_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> verif/tb_date_range_overlap_days_top.sv
// ----------------------------------------------------------------------------
// tb_date_range_overlap_days_top
// Self-checking bench for the date range overlap counter. The bench turns each
// date into a serial day number, predicts the shared inclusive day count and
// the invalid-date flag, and compares every rsp transaction with the oldest
// prediction. Stimulus runs directed calendar corners first, then random
// traffic with sender bursts, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_date_range_overlap_days_top;
   import drod_pkg::*;

   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int MAX_YEAR      = MAX_YEAR_DEF;
   localparam int COUNT_LIMIT   = (1 << COUNT_W) - 1;

   typedef struct {
      logic [COUNT_W-1:0] days;
      logic               bad_date;
   } overlap_result_type;

   typedef enum int {
      SHAPE_WELL_FORMED,
      SHAPE_ONE_BAD_FIELD,
      SHAPE_RAW
   } item_shape_type;

   typedef enum int {
      RSP_ALWAYS_READY,
      RSP_HALF_READY,
      RSP_MOSTLY_READY,
      RSP_MOSTLY_STALLED
   } rsp_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   overlap_result_type expected_overlaps[$];
   int                 fail_count;
   int                 idle_cycles;
   int                 burst_left;
   bit                 continuous_send;
   int                 rsp_hold_cycles;

   date_range_overlap_days_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- calendar
   function automatic bit is_leap_year(input int year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int month_length(input int month, input bit leap);
      case (month)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // serial 1 is 0001-01-01; returns 0 for a date that does not exist
   function automatic bit date_serial(input date_type dt, output int serial);
      int  y, m, d, p, m_idx;
      bit  leap;
      y      = int'(dt.year);
      m      = int'(dt.month);
      d      = int'(dt.day);
      serial = 0;
      if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1)
         return 0;
      leap = is_leap_year(y);
      if (d > month_length(m, leap))
         return 0;
      p      = y - 1;
      serial = 365 * p + p / 4 - p / 100 + p / 400 + d;
      for (m_idx = 1; m_idx < m; m_idx++)
         serial += month_length(m_idx, leap);
      return 1;
   endfunction

   function automatic overlap_result_type predict_overlap(input date_type a_start,
                                                          input date_type a_end,
                                                          input date_type b_start,
                                                          input date_type b_end);
      overlap_result_type res;
      int  sa, ea, sb, eb, first, last, count;
      bit  ok;
      ok = date_serial(a_start, sa);
      ok = date_serial(a_end, ea) && ok;
      ok = date_serial(b_start, sb) && ok;
      ok = date_serial(b_end, eb) && ok;
      count = 0;
      if (ok) begin
         first = (sa > sb) ? sa : sb;
         last  = (ea < eb) ? ea : eb;
         if (first <= last)
            count = last - first + 1;
         if (count > COUNT_LIMIT)
            count = COUNT_LIMIT;
      end
      res.days     = count[COUNT_W-1:0];
      res.bad_date = !ok;
      return res;
   endfunction

   function automatic date_type mk_date(input int year, input int month, input int day);
      date_type dt;
      dt.year  = year[YEAR_W-1:0];
      dt.month = month[MONTH_W-1:0];
      dt.day   = day[DAY_W-1:0];
      return dt;
   endfunction

   function automatic date_type rand_valid_date(input int year_lo, input int year_hi);
      int y, m, len;
      y   = $urandom_range(year_hi, year_lo);
      m   = $urandom_range(12, 1);
      len = month_length(m, is_leap_year(y));
      // month-end days get extra weight
      return mk_date(y, m, ($urandom_range(4, 0) == 0) ? len : $urandom_range(len, 1));
   endfunction

   // ---------------------------------------------------------------- sender
   // Entered at a falling edge; returns at a falling edge with req_tvalid still
   // high when the burst continues, so the next call follows without a gap.
   task automatic send_item(input date_type a_start, input date_type a_end,
                            input date_type b_start, input date_type b_end);
      logic [REQ_DATA_W-1:0] word;
      int                    gap;
      word                    = '0;
      word[4*DATE_W-1:0]      = {b_end, b_start, a_end, a_start};
      req_tdata  = word;
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      expected_overlaps.push_back(predict_overlap(a_start, a_end, b_start, b_end));
      @(negedge clock);
      if (!continuous_send) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
               req_tvalid = 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(60, 25)
                                                     : $urandom_range(12, 1);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_random_item();
      date_type       dt[4];
      date_type       tmp;
      item_shape_type shape;
      int             pick, span, base, i, s0, s1, victim;
      pick  = $urandom_range(99, 0);
      shape = (pick < 75) ? SHAPE_WELL_FORMED :
              (pick < 90) ? SHAPE_ONE_BAD_FIELD : SHAPE_RAW;
      pick = $urandom_range(9, 0);
      span = (pick < 6) ? 0 : (pick < 8) ? 1 : (pick < 9) ? 20 : MAX_YEAR - 1;
      base = $urandom_range(MAX_YEAR - span, 1);
      for (i = 0; i < 4; i++)
         dt[i] = rand_valid_date(base, base + span);
      // mostly keep each period in order so overlaps are common
      for (i = 0; i < 4; i += 2) begin
         if ($urandom_range(9, 0) != 0 && date_serial(dt[i], s0) &&
             date_serial(dt[i+1], s1) && s0 > s1) begin
            tmp     = dt[i];
            dt[i]   = dt[i+1];
            dt[i+1] = tmp;
         end
      end
      if (shape == SHAPE_ONE_BAD_FIELD) begin
         victim = $urandom_range(3, 0);
         case ($urandom_range(2, 0))
            0:       dt[victim].year  = YEAR_W'($urandom_range((1 << YEAR_W) - 1, 0));
            1:       dt[victim].month = MONTH_W'($urandom_range((1 << MONTH_W) - 1, 0));
            default: dt[victim].day   = DAY_W'($urandom_range((1 << DAY_W) - 1, 0));
         endcase
      end else if (shape == SHAPE_RAW) begin
         for (i = 0; i < 4; i++) begin
            dt[i].year  = YEAR_W'($urandom_range((1 << YEAR_W) - 1, 0));
            dt[i].month = MONTH_W'($urandom_range((1 << MONTH_W) - 1, 0));
            dt[i].day   = DAY_W'($urandom_range((1 << DAY_W) - 1, 0));
         end
      end
      send_item(dt[0], dt[1], dt[2], dt[3]);
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin : rsp_receiver
      rsp_mode_type mode;
      int           phase_left;
      mode       = RSP_ALWAYS_READY;
      phase_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            if (phase_left == 0) begin
               mode       = rsp_mode_type'($urandom_range(3, 0));
               phase_left = $urandom_range(150, 20);
            end
            phase_left--;
            case (mode)
               RSP_ALWAYS_READY:   rsp_tready = 1'b1;
               RSP_HALF_READY:     rsp_tready = 1'($urandom_range(1, 0));
               RSP_MOSTLY_READY:   rsp_tready = ($urandom_range(9, 0) != 0);
               default:            rsp_tready = ($urandom_range(3, 0) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      overlap_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_overlaps.size() == 0) begin
            $error("rsp transaction with no expected result pending");
            fail_count++;
         end else begin
            want = expected_overlaps.pop_front();
            if (rsp_tdata[COUNT_W-1:0] !== want.days) begin
               $error("overlap_days: expected %0d, actual %0d",
                      want.days, rsp_tdata[COUNT_W-1:0]);
               fail_count++;
            end
            if (rsp_tuser !== want.bad_date) begin
               $error("date_error: expected %0d, actual %0d", want.bad_date, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:COUNT_W] !== '0) begin
               $error("rsp_tdata pad: expected 0, actual %0h",
                      rsp_tdata[RSP_DATA_W-1:COUNT_W]);
               fail_count++;
            end
         end
      end
   end

   // no transaction on either side for too long means a hang
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_overlap_shapes();
      // partial overlap across a year end
      send_item(mk_date(2020, 1, 1), mk_date(2020, 12, 31),
                mk_date(2020, 6, 15), mk_date(2021, 3, 1));
      // identical periods
      send_item(mk_date(1999, 3, 10), mk_date(2001, 7, 4),
                mk_date(1999, 3, 10), mk_date(2001, 7, 4));
      // touching on one day
      send_item(mk_date(2010, 5, 1), mk_date(2010, 5, 20),
                mk_date(2010, 5, 20), mk_date(2010, 6, 30));
      // disjoint, both orders
      send_item(mk_date(1500, 1, 1), mk_date(1500, 1, 31),
                mk_date(1500, 2, 1), mk_date(1500, 2, 28));
      send_item(mk_date(1800, 2, 1), mk_date(1800, 2, 28),
                mk_date(1800, 1, 1), mk_date(1800, 1, 31));
      // period that ends before it starts
      send_item(mk_date(2005, 9, 30), mk_date(2005, 9, 1),
                mk_date(2005, 1, 1), mk_date(2005, 12, 31));
      // whole calendar on both sides: the largest count
      send_item(mk_date(1, 1, 1), mk_date(MAX_YEAR, 12, 31),
                mk_date(1, 1, 1), mk_date(MAX_YEAR, 12, 31));
      // one period inside the other
      send_item(mk_date(1, 1, 1), mk_date(MAX_YEAR, 12, 31),
                mk_date(4000, 2, 29), mk_date(4000, 3, 1));
   endtask

   task automatic test_month_lengths();
      send_item(mk_date(2000, 2, 29), mk_date(2000, 3, 1),
                mk_date(2000, 2, 1), mk_date(2000, 2, 29));
      // century year that is not a leap year
      send_item(mk_date(1900, 2, 29), mk_date(1900, 3, 1),
                mk_date(1900, 1, 1), mk_date(1900, 12, 31));
      send_item(mk_date(2024, 1, 31), mk_date(2024, 2, 29),
                mk_date(2024, 2, 29), mk_date(2024, 12, 31));
      send_item(mk_date(2023, 1, 1), mk_date(2023, 12, 31),
                mk_date(2023, 2, 29), mk_date(2023, 3, 31));
      send_item(mk_date(2021, 1, 1), mk_date(2021, 4, 31),
                mk_date(2021, 1, 1), mk_date(2021, 12, 31));
      send_item(mk_date(2021, 1, 1), mk_date(2021, 12, 31),
                mk_date(2021, 1, 1), mk_date(2024, 2, 30));
   endtask

   task automatic test_invalid_fields();
      send_item(mk_date(2000, 1, 0), mk_date(2000, 1, 31),
                mk_date(2000, 1, 1), mk_date(2000, 1, 31));
      send_item(mk_date(2000, 1, 1), mk_date(2000, 0, 15),
                mk_date(2000, 1, 1), mk_date(2000, 1, 31));
      send_item(mk_date(2000, 1, 1), mk_date(2000, 1, 31),
                mk_date(2000, 13, 1), mk_date(2000, 1, 31));
      send_item(mk_date(2000, 1, 1), mk_date(2000, 1, 31),
                mk_date(2000, 1, 1), mk_date(2000, 15, 31));
      send_item(mk_date(0, 6, 1), mk_date(2000, 1, 31),
                mk_date(2000, 1, 1), mk_date(2000, 1, 31));
      send_item(mk_date(2000, 1, 1), mk_date(MAX_YEAR + 1, 1, 1),
                mk_date(2000, 1, 1), mk_date(2000, 1, 31));
      send_item(mk_date(2000, 1, 1), mk_date(2000, 1, 31),
                mk_date(2000, 1, 1), mk_date((1 << YEAR_W) - 1, 12, 31));
   endtask

   // receiver holds off while the sender keeps offering, so the pipe backs up
   task automatic test_output_hold_off();
      continuous_send = 1'b1;
      rsp_hold_cycles = 300;
      repeat (60) send_random_item();
      continuous_send = 1'b0;
   endtask

   task automatic test_random_traffic();
      repeat (RANDOM_ITEMS) send_random_item();
   endtask

   initial begin : main
      fail_count      = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      continuous_send = 1'b0;
      rsp_hold_cycles = 0;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      reset           = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_overlap_shapes();
      test_month_lengths();
      test_invalid_fields();
      test_output_hold_off();
      test_random_traffic();
      req_tvalid = 1'b0;

      while (expected_overlaps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
